// ----- rtl/fault_latch_event_queue_macros.svh -----
// assertion helpers for the fault latch event queue checker
`ifndef FAULT_LATCH_EVENT_QUEUE_MACROS_SVH
`define FAULT_LATCH_EVENT_QUEUE_MACROS_SVH

// clocked property, switched off while reset is asserted
`define FLEQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// next-cycle implication built on the clocked form
`define FLEQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  `FLEQ_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

// ----- rtl/fleq_pkg.sv -----
package fleq_pkg;

  localparam int unsigned QUEUE_DEPTH  = 16;
  localparam int unsigned CONTEXT_BITS = 32;
  localparam int unsigned PTR_W        = $clog2(QUEUE_DEPTH);

  localparam int unsigned CODE_W = 32;
  localparam int unsigned SEQ_W  = 16;
  localparam int unsigned SEV_W  = 3;
  localparam int unsigned DOM_W  = 2;
  localparam int unsigned WORD_W = CONTEXT_BITS + SEQ_W + SEV_W + DOM_W + CODE_W;

  typedef logic [PTR_W-1:0] ptr_t;

  typedef enum logic [1:0] {
    ACT_REQ = 2'd0,
    ACT_CLR = 2'd1,
    ACT_POP = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    DOM_AXIS_A = 2'd0,
    DOM_AXIS_B = 2'd1,
    DOM_BUS    = 2'd2
  } domain_e;

  // controller to datapath
  typedef struct packed {
    logic take;   // input item accepted this cycle
    logic load;   // capture queue read data into the event registers
  } fleq_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic pop_hit;  // current input is a pop and the queue holds an event
  } fleq_status_t;

  function automatic ptr_t ptr_next(ptr_t p);
    ptr_t n;
    n = ptr_t'(p + ptr_t'(1));
    if (p == ptr_t'(QUEUE_DEPTH - 1)) begin
      n = '0;
    end
    return n;
  endfunction

endpackage

// ----- rtl/fleq_ram.sv -----
module fleq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/fleq_ctrl.sv -----
module fleq_ctrl
  import fleq_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_stall_o,
  output logic         out_valid_o,
  input  logic         out_stall_i,
  input  fleq_status_t status_i,
  output fleq_cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_LOAD = 3'b010,
    ST_OUT  = 3'b100
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d     = state_q;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    cmd_o       = '0;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          state_d    = status_i.pop_hit ? ST_LOAD : ST_OUT;
        end
      end
      ST_LOAD: begin
        cmd_o.load = 1'b1;
        state_d    = ST_OUT;
      end
      ST_OUT: begin
        out_valid_o = 1'b1;
        if (!out_stall_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- rtl/fleq_dp.sv -----
module fleq_dp
  import fleq_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  fleq_cmd_t         cmd_i,
  output fleq_status_t      status_o,
  input  logic [1:0]        action_i,
  input  logic [1:0]        domain_i,
  input  logic [31:0]       fault_bits_i,
  input  logic [2:0]        severity_i,
  input  logic [31:0]       context_word_i,
  output logic              pop_valid_o,
  output logic [1:0]        event_domain_o,
  output logic [31:0]       event_code_o,
  output logic [2:0]        event_severity_o,
  output logic [15:0]       event_sequence_o,
  output logic [31:0]       event_context_o,
  output logic [31:0]       flags_axis_a_o,
  output logic [31:0]       flags_axis_b_o,
  output logic [31:0]       flags_bus_o
  ,output logic [31:0]      dropped_count_o
);

  ptr_t              rd_ptr_q, wr_ptr_q, wr_nxt;
  logic [SEQ_W-1:0]  seq_q;
  logic [31:0]       drop_q;
  logic [31:0]       flag_a_q, flag_b_q, flag_bus_q;
  logic              empty, full, dom_ok, code_nz, req, clr, pop_hit, push;
  logic [63:0]       ctx_wide;
  logic [WORD_W-1:0] wdata, rdata;
  logic [CONTEXT_BITS-1:0] rd_ctx;
  logic [63:0]       rd_ctx_wide;

  logic              ev_valid_q;
  logic [1:0]        ev_dom_q;
  logic [31:0]       ev_code_q;
  logic [2:0]        ev_sev_q;
  logic [15:0]       ev_seq_q;
  logic [31:0]       ev_ctx_q;

  assign wr_nxt  = ptr_next(wr_ptr_q);
  assign empty   = (rd_ptr_q == wr_ptr_q);
  assign full    = (wr_nxt == rd_ptr_q);
  assign dom_ok  = (domain_i == DOM_AXIS_A) || (domain_i == DOM_AXIS_B) ||
                   (domain_i == DOM_BUS);
  assign code_nz = (fault_bits_i != '0);
  assign req     = cmd_i.take && (action_i == ACT_REQ) && dom_ok && code_nz;
  assign clr     = cmd_i.take && (action_i == ACT_CLR) && dom_ok && code_nz;
  assign pop_hit = (action_i == ACT_POP) && !empty;
  assign push    = req && !full;

  assign status_o.pop_hit = pop_hit;

  // stored context keeps its low CONTEXT_BITS bits
  assign ctx_wide = {32'h0, context_word_i};
  assign wdata    = {ctx_wide[CONTEXT_BITS-1:0], seq_q, severity_i, domain_i, fault_bits_i};

  fleq_ram #(
    .WIDTH(WORD_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (push),
    .waddr_i(wr_ptr_q),
    .wdata_i(wdata),
    .re_i   (cmd_i.take && pop_hit),
    .raddr_i(rd_ptr_q),
    .rdata_o(rdata)
  );

  assign rd_ctx      = rdata[WORD_W-1 -: CONTEXT_BITS];
  assign rd_ctx_wide = 64'(rd_ctx);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q   <= '0;
      wr_ptr_q   <= '0;
      seq_q      <= '0;
      drop_q     <= '0;
      flag_a_q   <= '0;
      flag_b_q   <= '0;
      flag_bus_q <= '0;
    end else begin
      if (req) begin
        case (domain_i)
          DOM_AXIS_A: flag_a_q   <= flag_a_q | fault_bits_i;
          DOM_AXIS_B: flag_b_q   <= flag_b_q | fault_bits_i;
          DOM_BUS:    flag_bus_q <= flag_bus_q | fault_bits_i;
          default: ;
        endcase
        if (full) begin
          drop_q <= drop_q + 32'd1;
        end else begin
          wr_ptr_q <= wr_nxt;
          seq_q    <= seq_q + SEQ_W'(1);
        end
      end
      if (clr) begin
        case (domain_i)
          DOM_AXIS_A: flag_a_q   <= flag_a_q & ~fault_bits_i;
          DOM_AXIS_B: flag_b_q   <= flag_b_q & ~fault_bits_i;
          DOM_BUS:    flag_bus_q <= flag_bus_q & ~fault_bits_i;
          default: ;
        endcase
      end
      if (cmd_i.take && pop_hit) begin
        rd_ptr_q <= ptr_next(rd_ptr_q);
      end
    end
  end

  // event registers: cleared on every item, filled from the queue on a pop that finds an event
  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      ev_valid_q <= 1'b0;
      ev_dom_q   <= '0;
      ev_code_q  <= '0;
      ev_sev_q   <= '0;
      ev_seq_q   <= '0;
      ev_ctx_q   <= '0;
    end else if (cmd_i.load) begin
      ev_valid_q <= 1'b1;
      ev_code_q  <= rdata[CODE_W-1:0];
      ev_dom_q   <= rdata[CODE_W +: DOM_W];
      ev_sev_q   <= rdata[CODE_W+DOM_W +: SEV_W];
      ev_seq_q   <= rdata[CODE_W+DOM_W+SEV_W +: SEQ_W];
      ev_ctx_q   <= rd_ctx_wide[31:0];
    end
  end

  assign pop_valid_o      = ev_valid_q;
  assign event_domain_o   = ev_dom_q;
  assign event_code_o     = ev_code_q;
  assign event_severity_o = ev_sev_q;
  assign event_sequence_o = ev_seq_q;
  assign event_context_o  = ev_ctx_q;
  assign flags_axis_a_o   = flag_a_q;
  assign flags_axis_b_o   = flag_b_q;
  assign flags_bus_o      = flag_bus_q;
  assign dropped_count_o  = drop_q;

endmodule

// ----- rtl/fault_latch_event_queue.sv -----
// channel | handshake              | payload
// --------+------------------------+-----------------------------------------------
// in      | in_valid_i, in_stall_o | action, domain, fault_bits, severity, context
// out     | out_valid_o, out_stall_i | pop_valid, event_*, flags_*, dropped_count
//
// one item at a time: result in the cycle after accept for every item but a pop that
// returns an event, which goes through the load state first (registered read of the queue ram)
// next item accepted the cycle after the result is taken
// reset clears bitmaps, pointers, sequence and drop counter; queue ram is not cleared
// in_stall_o is high from accept until the result is taken; a stalled result holds
module fault_latch_event_queue
  import fleq_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  action_i,
  input  logic [1:0]  domain_i,
  input  logic [31:0] fault_bits_i,
  input  logic [2:0]  severity_i,
  input  logic [31:0] context_word_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        pop_valid_o,
  output logic [1:0]  event_domain_o,
  output logic [31:0] event_code_o,
  output logic [2:0]  event_severity_o,
  output logic [15:0] event_sequence_o,
  output logic [31:0] event_context_o,
  output logic [31:0] flags_axis_a_o,
  output logic [31:0] flags_axis_b_o,
  output logic [31:0] flags_bus_o,
  output logic [31:0] dropped_count_o
);

  // command and status between sequencer and datapath
  fleq_cmd_t    cmd;
  fleq_status_t status;

  // sequencer: idle, queue read, result hold
  fleq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // datapath: bitmaps, ring pointers, counters, event queue ram
  fleq_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .action_i        (action_i),
    .domain_i        (domain_i),
    .fault_bits_i    (fault_bits_i),
    .severity_i      (severity_i),
    .context_word_i  (context_word_i),
    .pop_valid_o     (pop_valid_o),
    .event_domain_o  (event_domain_o),
    .event_code_o    (event_code_o),
    .event_severity_o(event_severity_o),
    .event_sequence_o(event_sequence_o),
    .event_context_o (event_context_o),
    .flags_axis_a_o  (flags_axis_a_o),
    .flags_axis_b_o  (flags_axis_b_o),
    .flags_bus_o     (flags_bus_o),
    .dropped_count_o (dropped_count_o)
  );

endmodule

// ----- rtl/fleq_checker.sv -----
`include "fault_latch_event_queue_macros.svh"

module fleq_checker
  import fleq_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic [1:0]  action_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        pop_valid_o,
  input logic [31:0] flags_axis_a_o,
  input logic [31:0] dropped_count_o
);

  logic in_acc;
  assign in_acc = in_valid_i && !in_stall_o;

  // no new item while a result waits
  `FLEQ_ASSERT(a_no_accept_while_out, out_valid_o |-> in_stall_o, "item accepted during result")

  // non-pop item reports on the next cycle with no event
  `FLEQ_ASSERT_NEXT(a_nonpop_result, in_acc && (action_i != ACT_POP), out_valid_o && !pop_valid_o, "non-pop result missing or shows an event")

  // a taken result is not offered twice
  `FLEQ_ASSERT_NEXT(a_single_result, out_valid_o && !out_stall_i, !out_valid_o, "result repeated")

  // drop count and axis A flags only move on an accepted item
  `FLEQ_ASSERT_NEXT(a_state_hold, !in_acc, $stable(dropped_count_o) && $stable(flags_axis_a_o), "state changed without an item")

endmodule

bind fault_latch_event_queue fleq_checker u_fleq_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .action_i       (action_i),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .pop_valid_o    (pop_valid_o),
  .flags_axis_a_o (flags_axis_a_o),
  .dropped_count_o(dropped_count_o)
);

// ----- verif/fault_latch_event_queue_checker.sv -----
`timescale 1ns / 100ps

module fault_latch_event_queue_checker
  import fleq_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [1:0]  action_i,
  input  logic [1:0]  domain_i,
  input  logic [31:0] fault_bits_i,
  input  logic [2:0]  severity_i,
  input  logic [31:0] context_word_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic        pop_valid_i,
  input  logic [1:0]  event_domain_i,
  input  logic [31:0] event_code_i,
  input  logic [2:0]  event_severity_i,
  input  logic [15:0] event_sequence_i,
  input  logic [31:0] event_context_i,
  input  logic [31:0] flags_axis_a_i,
  input  logic [31:0] flags_axis_b_i,
  input  logic [31:0] flags_bus_i,
  input  logic [31:0] dropped_count_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output int unsigned checked_o,
  output int unsigned popped_o
);

  typedef struct packed {
    logic        pop_valid;
    logic [1:0]  ev_domain;
    logic [31:0] ev_code;
    logic [2:0]  ev_severity;
    logic [15:0] ev_sequence;
    logic [31:0] ev_context;
    logic [31:0] flags_a;
    logic [31:0] flags_b;
    logic [31:0] flags_bus;
    logic [31:0] drops;
  } fault_report_t;

  localparam logic [63:0] CTX_MASK = {64{1'b1}} >> (64 - CONTEXT_BITS);

  // predicted block state
  logic [31:0] latched    [3];
  logic [31:0] slot_code  [QUEUE_DEPTH];
  logic [1:0]  slot_dom   [QUEUE_DEPTH];
  logic [2:0]  slot_sev   [QUEUE_DEPTH];
  logic [15:0] slot_seq   [QUEUE_DEPTH];
  logic [63:0] slot_ctx   [QUEUE_DEPTH];
  ptr_t        head;
  ptr_t        tail;
  logic [31:0] drop_total;
  logic [15:0] seq_next;

  fault_report_t predicted_reports[$];
  fault_report_t oldest;
  int unsigned   fails;
  int unsigned   checked;
  int unsigned   popped;

  function automatic ptr_t ring_inc(ptr_t p);
    return (p == ptr_t'(QUEUE_DEPTH - 1)) ? ptr_t'(0) : ptr_t'(p + 1'b1);
  endfunction

  task automatic step_fault_latch(input logic [1:0] act, input logic [1:0] dom,
                                  input logic [31:0] code, input logic [2:0] sev,
                                  input logic [31:0] ctx);
    fault_report_t r;
    ptr_t          nxt;
    r = '0;
    case (act)
      ACT_REQ: begin
        if (dom <= DOM_BUS && code != '0) begin
          latched[dom] = latched[dom] | code;
          nxt = ring_inc(tail);
          if (nxt == head) begin
            drop_total = drop_total + 1'b1;
          end else begin
            slot_code[tail] = code;
            slot_dom[tail]  = dom;
            slot_sev[tail]  = sev;
            slot_seq[tail]  = seq_next;
            slot_ctx[tail]  = {32'b0, ctx} & CTX_MASK;
            seq_next        = seq_next + 1'b1;
            tail            = nxt;
          end
        end
      end
      ACT_CLR: begin
        if (dom <= DOM_BUS && code != '0) begin
          latched[dom] = latched[dom] & ~code;
        end
      end
      ACT_POP: begin
        if (head != tail) begin
          r.pop_valid   = 1'b1;
          r.ev_domain   = slot_dom[head];
          r.ev_code     = slot_code[head];
          r.ev_severity = slot_sev[head];
          r.ev_sequence = slot_seq[head];
          r.ev_context  = slot_ctx[head][31:0];
          head          = ring_inc(head);
        end
      end
      default: ;
    endcase
    r.flags_a   = latched[DOM_AXIS_A];
    r.flags_b   = latched[DOM_AXIS_B];
    r.flags_bus = latched[DOM_BUS];
    r.drops     = drop_total;
    predicted_reports.push_back(r);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %h, actual %h", name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int d = 0; d < 3; d++) latched[d] = '0;
      head       = '0;
      tail       = '0;
      drop_total = '0;
      seq_next   = '0;
      predicted_reports.delete();
    end else begin
      // older result first, so a same-edge accept can never match itself
      if (out_valid_i && !out_stall_i) begin
        if (predicted_reports.size() == 0) begin
          $error("result item with no prediction waiting");
          fails++;
        end else begin
          oldest = predicted_reports.pop_front();
          check_field("pop_valid", 32'(oldest.pop_valid), 32'(pop_valid_i));
          check_field("event_domain", 32'(oldest.ev_domain), 32'(event_domain_i));
          check_field("event_code", oldest.ev_code, event_code_i);
          check_field("event_severity", 32'(oldest.ev_severity), 32'(event_severity_i));
          check_field("event_sequence", 32'(oldest.ev_sequence), 32'(event_sequence_i));
          check_field("event_context", oldest.ev_context, event_context_i);
          check_field("flags_axis_a", oldest.flags_a, flags_axis_a_i);
          check_field("flags_axis_b", oldest.flags_b, flags_axis_b_i);
          check_field("flags_bus", oldest.flags_bus, flags_bus_i);
          check_field("dropped_count", oldest.drops, dropped_count_i);
          checked++;
          if (oldest.pop_valid) popped++;
        end
      end
      if (in_valid_i && !in_stall_i) begin
        step_fault_latch(action_i, domain_i, fault_bits_i, severity_i, context_word_i);
      end
    end
    fail_count_o <= fails;
    pending_o    <= predicted_reports.size();
    checked_o    <= checked;
    popped_o     <= popped;
  end

endmodule

// ----- verif/fault_latch_event_queue_tb.sv -----
`timescale 1ns / 100ps

module fault_latch_event_queue_tb
  import fleq_pkg::*;
;

  // codes the package leaves unnamed
  localparam logic [1:0] ACT_UNUSED  = 2'd3;
  localparam logic [1:0] DOM_INVALID = 2'd3;

  localparam int unsigned LIMIT_CYCLES = 2_000_000;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned PHASE_ITEMS  = 125;

  logic clk_i;
  logic rst_ni = 1'b0;

  // input channel, known from time zero
  logic        in_valid_i     = 1'b0;
  logic        in_stall_o;
  logic [1:0]  action_i       = '0;
  logic [1:0]  domain_i       = '0;
  logic [31:0] fault_bits_i   = '0;
  logic [2:0]  severity_i     = '0;
  logic [31:0] context_word_i = '0;

  // result channel
  logic        out_valid_o;
  logic        out_stall_i    = 1'b0;
  logic        pop_valid_o;
  logic [1:0]  event_domain_o;
  logic [31:0] event_code_o;
  logic [2:0]  event_severity_o;
  logic [15:0] event_sequence_o;
  logic [31:0] event_context_o;
  logic [31:0] flags_axis_a_o;
  logic [31:0] flags_axis_b_o;
  logic [31:0] flags_bus_o;
  logic [31:0] dropped_count_o;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned checked;
  int unsigned popped;

  // knobs shared between the item sender and the result sink
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  bit          hold_phase = 1'b0;
  int unsigned items_sent = 0;

  fault_latch_event_queue uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .action_i         (action_i),
    .domain_i         (domain_i),
    .fault_bits_i     (fault_bits_i),
    .severity_i       (severity_i),
    .context_word_i   (context_word_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .pop_valid_o      (pop_valid_o),
    .event_domain_o   (event_domain_o),
    .event_code_o     (event_code_o),
    .event_severity_o (event_severity_o),
    .event_sequence_o (event_sequence_o),
    .event_context_o  (event_context_o),
    .flags_axis_a_o   (flags_axis_a_o),
    .flags_axis_b_o   (flags_axis_b_o),
    .flags_bus_o      (flags_bus_o),
    .dropped_count_o  (dropped_count_o)
  );

  fault_latch_event_queue_checker fault_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_i       (in_stall_o),
    .action_i         (action_i),
    .domain_i         (domain_i),
    .fault_bits_i     (fault_bits_i),
    .severity_i       (severity_i),
    .context_word_i   (context_word_i),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .pop_valid_i      (pop_valid_o),
    .event_domain_i   (event_domain_o),
    .event_code_i     (event_code_o),
    .event_severity_i (event_severity_o),
    .event_sequence_i (event_sequence_o),
    .event_context_i  (event_context_o),
    .flags_axis_a_i   (flags_axis_a_o),
    .flags_axis_b_i   (flags_axis_b_o),
    .flags_bus_i      (flags_bus_o),
    .dropped_count_i  (dropped_count_o),
    .fail_count_o     (fail_count),
    .pending_o        (pending),
    .checked_o        (checked),
    .popped_o         (popped)
  );

  // 4 ns clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // watchdog: a hung handshake ends the run here
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < LIMIT_CYCLES) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  // result sink: random stalls, plus one long hold-off when hold_phase rises
  initial begin : result_sink
    int unsigned hold_left;
    bit          hold_seen;
    hold_left = 0;
    hold_seen = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_phase && !hold_seen) hold_left = HOLD_CYCLES;
      hold_seen = hold_phase;
      if (hold_left != 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // offer one item, wait for the accepting edge; valid stays high so a
  // following item can go out back to back
  task automatic offer_item(input logic [1:0] act, input logic [1:0] dom,
                            input logic [31:0] code, input logic [2:0] sev,
                            input logic [31:0] ctx);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    action_i       <= act;
    domain_i       <= dom;
    fault_bits_i   <= code;
    severity_i     <= sev;
    context_word_i <= ctx;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    items_sent++;
  endtask

  // code or mask: mostly full random words, some single bits, a few zeros
  function automatic logic [31:0] pick_code();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 8) return '0;
    if (r < 38) return 32'd1 << $urandom_range(31);
    return $urandom;
  endfunction

  // req_pct steers the burst toward filling or draining the queue
  task automatic random_op(input int unsigned req_pct);
    int unsigned r;
    logic [1:0]  act;
    logic [1:0]  dom;
    logic [31:0] ctx;
    r = $urandom_range(99);
    if (r < req_pct) act = ACT_REQ;
    else if (r < req_pct + 15) act = ACT_CLR;
    else if (r < 96) act = ACT_POP;
    else act = ACT_UNUSED;
    // a few invalid domains as noise
    dom = ($urandom_range(99) < 8) ? DOM_INVALID : 2'($urandom_range(2));
    ctx = ($urandom_range(99) < 15) ? 32'h0 : 32'($urandom);
    offer_item(act, dom, pick_code(), 3'($urandom_range(7)), ctx);
  endtask

  initial begin : stimulus
    int unsigned send_mix[4];
    int unsigned recv_mix[4];
    int unsigned bias;

    // idling mixes: none, sender gappy, receiver stalling, both lightly
    send_mix = '{0, 83, 0, 12};
    recv_mix = '{0, 0, 83, 12};

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part
    offer_item(ACT_POP, DOM_AXIS_A, 32'h0, 3'd0, 32'h0);                     // pop on empty
    offer_item(ACT_REQ, DOM_AXIS_A, 32'hFFFF_FFFF, 3'd7, 32'hFFFF_FFFF);     // all ones
    offer_item(ACT_REQ, DOM_AXIS_B, 32'h0000_0001, 3'd0, 32'h0);             // absent context
    offer_item(ACT_REQ, DOM_BUS, 32'h8000_0000, 3'd5, 32'hA5A5_5A5A);
    offer_item(ACT_REQ, DOM_INVALID, 32'h0000_1234, 3'd2, 32'h1111_1111);    // ignored domain
    offer_item(ACT_REQ, DOM_AXIS_A, 32'h0, 3'd1, 32'h2222_2222);             // zero code
    offer_item(ACT_CLR, DOM_AXIS_A, 32'h0000_FFFF, 3'd0, 32'h0);
    offer_item(ACT_CLR, DOM_AXIS_B, 32'h0, 3'd0, 32'h0);                     // zero mask
    offer_item(ACT_CLR, DOM_INVALID, 32'hFFFF_FFFF, 3'd7, 32'hFFFF_FFFF);    // ignored domain
    offer_item(ACT_UNUSED, DOM_BUS, 32'hFFFF_FFFF, 3'd7, 32'hFFFF_FFFF);     // unused action
    // pops ignore every other field
    repeat (3) offer_item(ACT_POP, DOM_INVALID, 32'hFFFF_FFFF, 3'd7, 32'hFFFF_FFFF);
    offer_item(ACT_POP, DOM_BUS, 32'h0, 3'd0, 32'h0);                        // empty again
    // fill to one slot short of depth, then overflow into the drop counter
    repeat (QUEUE_DEPTH) offer_item(ACT_REQ, DOM_BUS, pick_code() | 32'h1,
                                    3'($urandom_range(7)), $urandom);

    // random part, bursts biased toward filling, draining or mixing
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = send_mix[ph];
      recv_stall_pct = recv_mix[ph];
      // long receiver hold-off while the sender keeps offering items
      if (ph == 0) hold_phase = 1'b1;
      for (int b = 0; b < PHASE_ITEMS / 25; b++) begin
        case ($urandom_range(2))
          0:       bias = 70;
          1:       bias = 15;
          default: bias = 40;
        endcase
        repeat (25) random_op(bias);
      end
      hold_phase = 1'b0;
    end

    // drain
    in_valid_i     <= 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    do @(posedge clk_i); while (pending != 0);
    repeat (20) @(posedge clk_i);

    $display("covered %0d items: directed cases, a queue overflow, four idling mixes",
             items_sent);
    $display("and a long result hold-off; %0d results compared, %0d returned events",
             checked, popped);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
